// ===== src/tdg_pkg.sv =====
`default_nettype none
package tdg_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int COUNT_W = 5;

    localparam int IN_TDATA_W = 72;
    localparam int IN_TUSER_W = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    localparam logic [47:0] WMAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [30:0] DELTA_RESET = 31'd3277;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_COMPRESS = 2'd2;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_STANDARD = 2'd1;
    localparam logic [1:0] MODE_AGGRESSIVE = 2'd2;

    localparam logic REG_MERGE_DELTA = 1'b0;
    localparam logic REG_COMPRESSION_MODE = 1'b1;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_ANSWERED = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_COMPRESSED = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_GAP,
        S_GAP_PICK,
        S_RUN_INIT,
        S_RUN_READ,
        S_RUN_DECIDE,
        S_RUN_DIV,
        S_RUN_FINAL,
        S_ADD_CHECK,
        S_INS_SCAN,
        S_INS_SHIFT,
        S_Q_INIT,
        S_Q_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       set_std;
        logic       gap_init;
        logic       gap_step;
        logic       gap_pick;
        logic       run_init;
        logic       run_read;
        logic       run_keep;
        logic       div_start;
        logic       div_finish;
        logic       run_final;
        logic       ins_init;
        logic       ins_step;
        logic       shift_init;
        logic       shift_step;
        logic       ins_write;
        logic       q_init;
        logic       q_step;
        logic       q_hit;
        logic       set_status;
        logic [2:0] status;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] mode;
        logic       held_ge_cap;
        logic       held_lt2;
        logic       held_zero;
        logic       at_last;
        logic       join_ok;
        logic       div_done;
        logic       scan_go;
        logic       shift_more;
        logic       q_stop;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== src/fixed_capacity_t_digest.sv =====
// Quantile sketch holding up to CAPACITY (mean, weight) centroids sorted by mean.
// Requests enter on the s_axis channel; tuser carries the operation (add, query,
// compress). Each request yields exactly one result on the m_axis channel with a
// status in tuser and the query answer and centroid count in tdata.
// The cfg port writes merge_delta (index 0) and compression_mode (index 1); write
// it only while no request is in flight.
// One request is processed at a time. s_axis_tready is high only while the
// controller waits for a request. Steps from acceptance to result:
//   add without compression: dispatch, room check, insertion scan, shift, write;
//   query: dispatch, setup, then a scan up to the position of the answer;
//   compression: a read and a decision per neighbour, plus a merge through
//   the bit-serial weighted-mean divider for each pair joined; in aggressive
//   mode an add that finds the sketch full first scans the gaps between centroids.
// The result sits in an output register; the next request is accepted while it
// waits, and the controller stalls only if a second result is ready before the
// first one is taken. Reset empties the sketch and restores the register defaults.
`default_nettype none
module fixed_capacity_t_digest
    import tdg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [30:0]            cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // sample_value [31:0], sample_weight [47:32], quantile [64:48]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation [1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // quantile_mean [31:0], centroid_count [36:32]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // status [2:0]
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser
);

    cmd_t cmd;
    sts_t sts;

    tdg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tdg_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_tdata   (s_axis_tdata),
        .in_tuser   (s_axis_tuser),
        .cmd        (cmd),
        .sts        (sts),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== src/tdg_ctrl.sv =====
`default_nettype none
module tdg_ctrl
    import tdg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  sts_t      sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_ADD:
                    begin
                        if (sts.held_ge_cap && sts.mode == MODE_STANDARD)
                        begin
                            state_next = S_RUN_INIT;
                        end
                        else if (sts.held_ge_cap && sts.mode == MODE_AGGRESSIVE)
                        begin
                            state_next = S_GAP;
                        end
                        else
                        begin
                            state_next = S_ADD_CHECK;
                        end
                    end
                    OP_QUERY:
                    begin
                        state_next = sts.held_zero ? S_DONE : S_Q_INIT;
                    end
                    OP_COMPRESS:
                    begin
                        state_next = S_RUN_INIT;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_GAP:
            begin
                if (sts.at_last)
                begin
                    state_next = S_GAP_PICK;
                end
            end
            S_GAP_PICK:
            begin
                state_next = S_RUN_INIT;
            end
            S_RUN_INIT:
            begin
                if (sts.held_lt2)
                begin
                    state_next = (sts.op == OP_ADD) ? S_ADD_CHECK : S_DONE;
                end
                else
                begin
                    state_next = S_RUN_READ;
                end
            end
            S_RUN_READ:
            begin
                state_next = S_RUN_DECIDE;
            end
            S_RUN_DECIDE:
            begin
                if (sts.join_ok)
                begin
                    state_next = S_RUN_DIV;
                end
                else
                begin
                    state_next = sts.at_last ? S_RUN_FINAL : S_RUN_READ;
                end
            end
            S_RUN_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = sts.at_last ? S_RUN_FINAL : S_RUN_READ;
                end
            end
            S_RUN_FINAL:
            begin
                state_next = (sts.op == OP_ADD) ? S_ADD_CHECK : S_DONE;
            end
            S_ADD_CHECK:
            begin
                state_next = sts.held_ge_cap ? S_DONE : S_INS_SCAN;
            end
            S_INS_SCAN:
            begin
                if (!sts.scan_go)
                begin
                    state_next = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT:
            begin
                if (!sts.shift_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_Q_INIT:
            begin
                state_next = S_Q_SCAN;
            end
            S_Q_SCAN:
            begin
                if (sts.q_stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_in = in_valid;
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_ADD:
                    begin
                        if (sts.held_ge_cap && sts.mode == MODE_STANDARD)
                        begin
                            cmd.set_std = 1'b1;
                        end
                        else if (sts.held_ge_cap && sts.mode == MODE_AGGRESSIVE)
                        begin
                            cmd.gap_init = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (sts.held_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = ST_EMPTY;
                        end
                    end
                    OP_COMPRESS:
                    begin
                        cmd.set_std = 1'b1;
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status = ST_DROPPED;
                    end
                endcase
            end
            S_GAP:
            begin
                cmd.gap_step = 1'b1;
            end
            S_GAP_PICK:
            begin
                cmd.gap_pick = 1'b1;
            end
            S_RUN_INIT:
            begin
                if (sts.held_lt2)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = ST_COMPRESSED;
                end
                else
                begin
                    cmd.run_init = 1'b1;
                end
            end
            S_RUN_READ:
            begin
                cmd.run_read = 1'b1;
            end
            S_RUN_DECIDE:
            begin
                if (sts.join_ok)
                begin
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.run_keep = 1'b1;
                end
            end
            S_RUN_DIV:
            begin
                cmd.div_finish = sts.div_done;
            end
            S_RUN_FINAL:
            begin
                cmd.run_final = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status = ST_COMPRESSED;
            end
            S_ADD_CHECK:
            begin
                if (sts.held_ge_cap)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = ST_DROPPED;
                end
                else
                begin
                    cmd.ins_init = 1'b1;
                end
            end
            S_INS_SCAN:
            begin
                if (sts.scan_go)
                begin
                    cmd.ins_step = 1'b1;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                end
            end
            S_INS_SHIFT:
            begin
                if (sts.shift_more)
                begin
                    cmd.shift_step = 1'b1;
                end
                else
                begin
                    cmd.ins_write = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status = ST_ADDED;
                end
            end
            S_Q_INIT:
            begin
                cmd.q_init = 1'b1;
            end
            S_Q_SCAN:
            begin
                if (sts.q_stop)
                begin
                    cmd.q_hit = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status = ST_ANSWERED;
                end
                else
                begin
                    cmd.q_step = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/tdg_muldiv.sv =====
`default_nettype none
module tdg_muldiv
    import tdg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a,
    input  wire logic [47:0] b,
    input  wire logic [48:0] c,
    output logic             done,
    output logic [31:0]      q
);

    // Computes floor(a * b / c) for b <= c, two restoring steps per bit of a.
    logic        busy_reg;
    logic        done_reg;
    logic        phase_reg;
    logic [4:0]  k_reg;
    logic [31:0] a_reg;
    logic [47:0] b_reg;
    logic [48:0] c_reg;
    logic [49:0] r_reg;
    logic [31:0] q_reg;

    logic [49:0] r_dbl;
    logic [49:0] r_add;
    logic [49:0] r_try;
    logic        r_ge;

    always_comb
    begin
        r_dbl = {r_reg[48:0], 1'b0};
        r_add = r_reg + {2'b00, b_reg};
        r_try = phase_reg ? r_add : r_dbl;
        r_ge = (r_try >= {1'b0, c_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            phase_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                phase_reg <= 1'b0;
                k_reg <= 5'd31;
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    if (k_reg == 5'd0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg - 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            c_reg <= c;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                r_reg <= r_ge ? (r_try - {1'b0, c_reg}) : r_try;
                q_reg <= {q_reg[30:0], r_ge};
            end
            else if (a_reg[k_reg])
            begin
                r_reg <= r_ge ? (r_try - {1'b0, c_reg}) : r_try;
                q_reg <= q_reg + {31'd0, r_ge};
            end
        end
    end

    assign done = done_reg;
    assign q = q_reg;

endmodule
`default_nettype wire

// ===== src/tdg_dp.sv =====
`default_nettype none
module tdg_dp
    import tdg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [30:0]            cfg_wdata,
    input  wire logic [IN_TDATA_W-1:0]  in_tdata,
    input  wire logic [IN_TUSER_W-1:0]  in_tuser,
    input  cmd_t                        cmd,
    output sts_t                        sts,
    output logic                        out_tvalid,
    input  wire logic                   out_tready,
    output logic [OUT_TDATA_W-1:0]      out_tdata,
    output logic [OUT_TUSER_W-1:0]      out_tuser
);

    function automatic logic [31:0] abs_diff(input logic [31:0] x, input logic [31:0] y);
        logic [32:0] diff;
        diff = {x[31], x} - {y[31], y};
        abs_diff = diff[32] ? 32'(-diff) : diff[31:0];
    endfunction

    logic [31:0] mean_mem [CAPACITY];
    logic [47:0] weight_mem [CAPACITY];

    logic [30:0]      delta_reg;
    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] held_reg;
    logic [47:0]      total_reg;
    logic             out_valid_reg;

    logic [1:0]       op_reg;
    logic [31:0]      val_reg;
    logic [15:0]      wt_reg;
    logic [16:0]      p_reg;
    logic [2:0]       status_reg;
    logic [31:0]      answer_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] n_reg;
    logic [31:0]      prev_reg;
    logic [31:0]      gap_reg;
    logic [31:0]      thr_reg;
    logic             weighted_reg;
    logic [31:0]      cm_reg;
    logic [47:0]      cw_reg;
    logic [31:0]      m_reg;
    logic [47:0]      wm_reg;
    logic [31:0]      d_reg;
    logic [48:0]      sum_reg;
    logic [63:0]      target_reg;
    logic [47:0]      cum_reg;
    logic [2:0]       out_status_reg;
    logic [31:0]      out_mean_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_mean;
    logic [47:0]      rd_weight;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_mean;
    logic [47:0]      wr_weight;

    logic [31:0]      d_gap;
    logic [31:0]      d_run;
    logic [48:0]      sum_run;
    logic [61:0]      prod;
    logic             join_w;
    logic             join_u;
    logic             cm_gt;
    logic [31:0]      lo_mean;
    logic             div_done;
    logic [31:0]      div_q;
    logic [48:0]      cum_sum;
    logic [64:0]      target_full;
    logic [48:0]      total_sum;
    logic [CNT_W-1:0] held_m1;
    logic [15:0]      in_weight;
    logic [16:0]      in_p;

    always_comb
    begin
        if (cmd.gap_init || cmd.run_init)
        begin
            rd_addr = '0;
        end
        else if (cmd.shift_step)
        begin
            rd_addr = IDX_W'(idx_reg - 1'b1);
        end
        else
        begin
            rd_addr = idx_reg[IDX_W-1:0];
        end
    end

    assign rd_mean = mean_mem[rd_addr];
    assign rd_weight = weight_mem[rd_addr];

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = n_reg[IDX_W-1:0];
        wr_mean = cm_reg;
        wr_weight = cw_reg;
        if (cmd.run_keep || cmd.run_final)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift_step)
        begin
            wr_en = 1'b1;
            wr_addr = idx_reg[IDX_W-1:0];
            wr_mean = rd_mean;
            wr_weight = rd_weight;
        end
        else if (cmd.ins_write)
        begin
            wr_en = 1'b1;
            wr_addr = pos_reg[IDX_W-1:0];
            wr_mean = val_reg;
            wr_weight = {32'd0, wt_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mean_mem[wr_addr] <= wr_mean;
            weight_mem[wr_addr] <= wr_weight;
        end
    end

    always_comb
    begin
        d_gap = abs_diff(rd_mean, prev_reg);
        d_run = abs_diff(rd_mean, cm_reg);
        sum_run = {1'b0, cw_reg} + {1'b0, rd_weight};
        prod = sum_reg[30:0] * d_reg[30:0];
        join_w = (d_reg == 32'd0)
              || ((sum_reg[48:31] == '0) && !d_reg[31] && (prod <= 62'(thr_reg)));
        join_u = (d_reg <= thr_reg);
        cm_gt = ($signed(cm_reg) > $signed(m_reg));
        lo_mean = cm_gt ? m_reg : cm_reg;
        cum_sum = {1'b0, cum_reg} + {1'b0, rd_weight};
        target_full = p_reg * total_reg;
        total_sum = {1'b0, total_reg} + {33'd0, wt_reg};
        held_m1 = held_reg - 1'b1;
        in_weight = (in_tdata[47:32] == 16'd0) ? 16'd1 : in_tdata[47:32];
        in_p = (in_tdata[64:48] > 17'd65536) ? 17'd65536 : in_tdata[64:48];
    end

    tdg_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .a     (d_reg),
        .b     (cm_gt ? cw_reg : wm_reg),
        .c     (sum_reg),
        .done  (div_done),
        .q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg <= DELTA_RESET;
            mode_reg <= MODE_AGGRESSIVE;
            held_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_MERGE_DELTA)
            begin
                delta_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == REG_COMPRESSION_MODE)
            begin
                mode_reg <= cfg_wdata[1:0];
            end
            if (cmd.run_final)
            begin
                held_reg <= n_reg + 1'b1;
            end
            else if (cmd.ins_write)
            begin
                held_reg <= held_reg + 1'b1;
                total_reg <= total_sum[48] ? WMAX : total_sum[47:0];
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= in_tuser;
            val_reg <= in_tdata[31:0];
            wt_reg <= in_weight;
            p_reg <= in_p;
            answer_reg <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.set_std)
        begin
            thr_reg <= {1'b0, delta_reg};
            weighted_reg <= 1'b1;
        end
        if (cmd.gap_init)
        begin
            gap_reg <= '1;
            prev_reg <= rd_mean;
            idx_reg <= CNT_W'(1);
        end
        if (cmd.gap_step)
        begin
            gap_reg <= (d_gap < gap_reg) ? d_gap : gap_reg;
            prev_reg <= rd_mean;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.gap_pick)
        begin
            if (gap_reg > {1'b0, delta_reg})
            begin
                thr_reg <= gap_reg;
                weighted_reg <= 1'b0;
            end
            else
            begin
                thr_reg <= {1'b0, delta_reg};
                weighted_reg <= 1'b1;
            end
        end
        if (cmd.run_init)
        begin
            cm_reg <= rd_mean;
            cw_reg <= rd_weight;
            idx_reg <= CNT_W'(1);
            n_reg <= '0;
        end
        if (cmd.run_read)
        begin
            m_reg <= rd_mean;
            wm_reg <= rd_weight;
            d_reg <= d_run;
            sum_reg <= sum_run;
        end
        if (cmd.run_keep)
        begin
            n_reg <= n_reg + 1'b1;
            cm_reg <= m_reg;
            cw_reg <= wm_reg;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.div_finish)
        begin
            cm_reg <= lo_mean + div_q;
            cw_reg <= sum_reg[48] ? WMAX : sum_reg[47:0];
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.ins_init)
        begin
            idx_reg <= '0;
        end
        if (cmd.ins_step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.shift_init)
        begin
            pos_reg <= idx_reg;
            idx_reg <= held_reg;
        end
        if (cmd.shift_step)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.q_init)
        begin
            target_reg <= target_full[63:0];
            cum_reg <= '0;
            idx_reg <= '0;
        end
        if (cmd.q_step)
        begin
            cum_reg <= cum_sum[47:0];
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.q_hit)
        begin
            answer_reg <= rd_mean;
        end
        if (cmd.emit)
        begin
            out_status_reg <= status_reg;
            out_mean_reg <= answer_reg;
            out_count_reg <= COUNT_W'(held_reg);
        end
    end

    always_comb
    begin
        sts.op = op_reg;
        sts.mode = mode_reg;
        sts.held_ge_cap = (held_reg >= CNT_W'(CAPACITY));
        sts.held_lt2 = (held_reg < CNT_W'(2));
        sts.held_zero = (held_reg == '0);
        sts.at_last = (idx_reg == held_m1);
        sts.join_ok = weighted_reg ? join_w : join_u;
        sts.div_done = div_done;
        sts.scan_go = (idx_reg < held_reg) && ($signed(rd_mean) < $signed(val_reg));
        sts.shift_more = (idx_reg > pos_reg);
        sts.q_stop = cum_sum[48] || ({cum_sum[47:0], 16'h0000} > target_reg)
                  || (idx_reg == held_m1);
        sts.out_free = !out_valid_reg || out_tready;
    end

    assign out_tvalid = out_valid_reg;
    assign out_tuser = out_status_reg;
    assign out_tdata = {3'b000, out_count_reg, out_mean_reg};

endmodule
`default_nettype wire

// ===== src/tdg_checker.sv =====
`default_nettype none
module tdg_checker
    import tdg_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_we,
    input wire logic                   cfg_index,
    input wire logic [30:0]            cfg_wdata,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted in back-to-back cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:32] <= COUNT_W'(CAPACITY))
        else $error("centroid count above capacity");

    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_ANSWERED |-> m_axis_tdata[31:0] == 32'd0)
        else $error("nonzero mean on a non-query result");

    a_added_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_ADDED |-> m_axis_tdata[36:32] != '0)
        else $error("added result reports an empty sketch");

endmodule

bind fixed_capacity_t_digest tdg_checker u_tdg_checker (.*);
`default_nettype wire
